// ===== rtl/sbda_pkg.sv =====
// shared types, constants and sizing functions for the signed binary to decimal ascii block
// no dependencies
`default_nettype none

package sbda_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int BITS_PER_STEP      = 3;
    localparam int DIGIT_BITS         = 4;
    localparam int CHAR_BITS          = 6;
    localparam int COUNT_BITS         = 4;

    localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 6'd45;
    localparam logic [CHAR_BITS-1:0] ZERO_CHAR  = 6'd48;

    // decimal digits of 2^(vb-1), exact for vb up to 64
    function automatic int digits_for(input int vb);
        return (((vb - 1) * 1233) >> 12) + 1;
    endfunction

    // shift steps of BITS_PER_STEP bits that cover vb bits
    function automatic int steps_for(input int vb);
        return (vb + BITS_PER_STEP - 1) / BITS_PER_STEP;
    endfunction

    // hand-off from the converter chain to the character emitter
    typedef struct packed {
        logic load;
        logic neg;
        logic stream;
    } t_emit_ctl;

    // emitter status back to the top level
    typedef struct packed {
        logic ready;
        logic strobe;
        logic last;
    } t_emit_status;

endpackage

`default_nettype wire

// ===== rtl/sbda_cell.sv =====
// one bcd digit cell of the shift-and-add-3 chain, three bits per clock while enabled
// depends on sbda_pkg
`default_nettype none

module sbda_cell
    import sbda_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_clr,
    input  wire logic                     i_en,
    input  wire logic [BITS_PER_STEP-1:0] i_bits,
    output logic      [BITS_PER_STEP-1:0] o_bits,
    output logic      [DIGIT_BITS-1:0]    o_digit
);

    logic [DIGIT_BITS-1:0] r_digit;
    logic [DIGIT_BITS-1:0] n_digit;

    // bit BITS_PER_STEP-1 is consumed first
    always_comb begin
        logic [DIGIT_BITS-1:0] d;
        d      = r_digit;
        o_bits = '0;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            o_bits[s] = d[DIGIT_BITS-1];
            d = {d[DIGIT_BITS-2:0], i_bits[s]};
        end
        n_digit = d;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_digit <= '0;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ===== rtl/sbda_emit.sv =====
// character emitter: holds one converted value and sends it out one character a clock
// depends on sbda_pkg
`default_nettype none

module sbda_emit
    import sbda_pkg::*;
#(
    parameter int NDIG = digits_for(DEFAULT_VALUE_BITS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_emit_ctl                  i_ctl,
    input  wire logic [NDIG*DIGIT_BITS-1:0] i_digits,
    output t_emit_status                    o_status,
    output logic      [CHAR_BITS-1:0]       o_character,
    output logic                            o_error_stream,
    output logic      [COUNT_BITS-1:0]      o_char_count
);

    localparam int PW = $clog2(NDIG);
    localparam int CW = $clog2(NDIG + 2);

    logic                  r_busy;
    logic                  n_busy;
    logic                  r_minus;
    logic                  n_minus;
    logic [PW-1:0]         r_ptr;
    logic [PW-1:0]         n_ptr;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_stream;
    logic [DIGIT_BITS-1:0] r_dig [NDIG];
    logic [PW-1:0]         w_lead;
    logic                  w_last;
    logic [CW+COUNT_BITS-1:0] w_count_ext;

    // highest nonzero digit, zero when the value is zero
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (i_digits[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                w_lead = PW'(i);
            end
        end
    end

    assign w_last = r_busy && !r_minus && (r_ptr == '0);

    always_comb begin
        n_busy  = r_busy;
        n_minus = r_minus;
        n_ptr   = r_ptr;
        n_count = r_count;
        if (r_busy) begin
            n_count = r_count + 1'b1;
            if (r_minus) begin
                n_minus = 1'b0;
            end else if (r_ptr != '0) begin
                n_ptr = r_ptr - 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end
        if (i_ctl.load) begin
            n_busy  = 1'b1;
            n_minus = i_ctl.neg;
            n_ptr   = w_lead;
            n_count = CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_minus <= n_minus;
        r_ptr   <= n_ptr;
        r_count <= n_count;
        if (i_ctl.load) begin
            r_stream <= i_ctl.stream;
            for (int i = 0; i < NDIG; i++) begin
                r_dig[i] <= i_digits[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    assign w_count_ext = {{COUNT_BITS{1'b0}}, r_count};

    assign o_status.ready  = !r_busy || w_last;
    assign o_status.strobe = r_busy;
    assign o_status.last   = w_last;
    assign o_character     = r_minus ? MINUS_CHAR
                                     : ZERO_CHAR + {2'b00, r_dig[r_ptr]};
    assign o_error_stream  = r_stream;
    assign o_char_count    = w_count_ext[COUNT_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// signed binary to decimal ascii: a chain of bcd cells converts the magnitude 3 bits a clock,
// then the emitter sends one character per clock; a value emits up to 11 characters at 32 bits.
// the next value converts while the previous one is emitted, so a new value can be taken
// before the characters of the previous one are all out.
// synchronous active-low reset clears control only; the receiver cannot stall.
// depends on sbda_pkg, sbda_cell, sbda_emit
`default_nettype none

module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic                         i_to_error_stream,
    output logic                              o_strobe,
    output logic             [CHAR_BITS-1:0]  o_character,
    output logic                              o_error_stream,
    output logic             [COUNT_BITS-1:0] o_char_count,
    output logic                              o_last
);

    localparam int NDIG  = digits_for(VALUE_BITS);
    localparam int STEPS = steps_for(VALUE_BITS);
    localparam int PAD   = STEPS * BITS_PER_STEP;
    localparam int SW    = $clog2(STEPS);

    // converter control
    logic            r_cv_busy;
    logic            n_cv_busy;
    logic            r_cv_done;
    logic            n_cv_done;
    logic [SW-1:0]   r_step;
    logic [SW-1:0]   n_step;
    logic [PAD-1:0]  r_mag;
    logic [PAD-1:0]  n_mag;
    logic            r_neg;
    logic            r_stream;

    logic                  w_accept;
    logic                  w_handoff;
    logic [VALUE_BITS-1:0] w_abs;
    t_emit_ctl             w_ctl;
    t_emit_status          w_status;

    logic [BITS_PER_STEP-1:0]   w_ob [NDIG];
    logic [BITS_PER_STEP-1:0]   w_ib [NDIG];
    logic [NDIG*DIGIT_BITS-1:0] w_digits;

    // finished conversion moves to the emitter as soon as it can take it;
    // a new value may be accepted in that same cycle
    assign w_handoff = r_cv_done && w_status.ready;
    assign busy      = r_cv_busy || (r_cv_done && !w_status.ready);
    assign w_accept  = start && !busy;

    // magnitude through two's complement negate, most negative value included
    assign w_abs = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    always_comb begin
        n_cv_busy = r_cv_busy;
        n_cv_done = r_cv_done;
        n_step    = r_step;
        n_mag     = r_mag;
        if (w_handoff) begin
            n_cv_done = 1'b0;
        end
        if (r_cv_busy) begin
            n_mag  = r_mag << BITS_PER_STEP;
            n_step = r_step + 1'b1;
            if (r_step == SW'(STEPS - 1)) begin
                n_cv_busy = 1'b0;
                n_cv_done = 1'b1;
            end
        end
        if (w_accept) begin
            n_cv_busy = 1'b1;
            n_step    = '0;
            n_mag     = PAD'(w_abs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_busy <= 1'b0;
            r_cv_done <= 1'b0;
        end else begin
            r_cv_busy <= n_cv_busy;
            r_cv_done <= n_cv_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_mag  <= n_mag;
        if (w_accept) begin
            r_neg    <= i_value[VALUE_BITS-1];
            r_stream <= i_to_error_stream;
        end
    end

    // cell chain, cell 0 is the least significant digit and takes the magnitude bits
    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_ib[g] = r_mag[PAD-1 -: BITS_PER_STEP];
        end else begin : g_rest
            assign w_ib[g] = w_ob[g-1];
        end
        sbda_cell u_cell (
            .i_clk   (i_clk),
            .i_clr   (w_accept),
            .i_en    (r_cv_busy),
            .i_bits  (w_ib[g]),
            .o_bits  (w_ob[g]),
            .o_digit (w_digits[g*DIGIT_BITS +: DIGIT_BITS])
        );
    end

    assign w_ctl.load   = w_handoff;
    assign w_ctl.neg    = r_neg;
    assign w_ctl.stream = r_stream;

    sbda_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_digits       (w_digits),
        .o_status       (w_status),
        .o_character    (o_character),
        .o_error_stream (o_error_stream),
        .o_char_count   (o_char_count)
    );

    assign o_strobe = w_status.strobe;
    assign o_last   = w_status.last;

`ifndef SYNTHESIS
    // a value's characters leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a value's characters");

    // a new value's first beat counts from one
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe || (o_char_count == 4'd1))
        else $error("character count did not restart");

    // the minus sign only leads
    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_character == MINUS_CHAR) |-> (o_char_count == 4'd1) && !o_last)
        else $error("minus sign out of place");

    // an accepted value keeps the converter occupied
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("converter not busy after accept");
`endif

endmodule

`default_nettype wire
